>>> sv/cfe_pkg.sv
`default_nettype none

package cfe_pkg;

  // Character codes the parser and the console react to.
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  localparam logic [3:0] SIZE_RESET = 4'd4;
  localparam logic [3:0] SIZE_MAX   = 4'd8;
  localparam logic [3:0] DEC_TOP    = 4'd9;
  localparam logic [3:0] HEX_TOP    = 4'd7;
  localparam logic [7:0] ROW_LIMIT  = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAR,
    ST_SIGN,
    ST_HEX,
    ST_DEC
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CHAR,
    OP_HEX,
    OP_DEC
  } op_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_CHAR,
    EM_MINUS,
    EM_HEX,
    EM_DEC
  } emit_t;

  typedef struct packed {
    logic  accept;
    emit_t emit;
    logic  skip;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic neg;
    logic out_free;
    logic idx_zero;
    logic hex_skip;
    logic dec_skip;
  } dp_status_t;

  function automatic logic [35:0] pow10(input logic [3:0] k);
    logic [35:0] p;
    case (k)
      4'd0: p = 36'd1;
      4'd1: p = 36'd10;
      4'd2: p = 36'd100;
      4'd3: p = 36'd1000;
      4'd4: p = 36'd10000;
      4'd5: p = 36'd100000;
      4'd6: p = 36'd1000000;
      4'd7: p = 36'd10000000;
      4'd8: p = 36'd100000000;
      4'd9: p = 36'd1000000000;
      default: p = 36'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    logic [7:0] g;
    if (nib < 4'd10) begin
      g = CH_ZERO + {4'b0, nib};
    end else begin
      g = CH_UPPER_A + {4'b0, nib} - 8'd10;
    end
    return g;
  endfunction

endpackage

`default_nettype wire

>>> sv/cfe_controller.sv
`default_nettype none

module cfe_controller
  import cfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.accept = 1'b0;
    cmd.emit   = EM_NONE;
    cmd.skip   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          case (status.op)
            OP_CHAR: state_next = ST_CHAR;
            OP_HEX:  state_next = ST_HEX;
            OP_DEC:  state_next = status.neg ? ST_SIGN : ST_DEC;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CHAR: begin
        if (status.out_free) begin
          cmd.emit   = EM_CHAR;
          state_next = ST_IDLE;
        end
      end
      ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit   = EM_MINUS;
          state_next = ST_DEC;
        end
      end
      ST_HEX: begin
        if (status.hex_skip) begin
          cmd.skip = 1'b1;
        end else if (status.out_free) begin
          cmd.emit = EM_HEX;
          if (status.idx_zero) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DEC: begin
        if (status.dec_skip) begin
          cmd.skip = 1'b1;
        end else if (status.out_free) begin
          cmd.emit = EM_DEC;
          if (status.idx_zero) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/cfe_datapath.sv
`default_nettype none

module cfe_datapath
  import cfe_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctrl_cmd_t   cmd,
  input  wire logic [39:0] s_tdata,
  input  wire logic        s_tuser,
  output dp_status_t       status,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,
  output logic             m_tuser,
  output logic             m_tlast
);

  logic [7:0]  format_char;
  logic [31:0] argument_value;
  logic        first_of_format;

  // Parser and console state.
  logic        mode;
  logic [3:0]  size;
  logic [6:0]  col;
  logic [7:0]  row;

  // Conversion working registers.
  logic [7:0]  ch;
  logic [31:0] work;
  logic [3:0]  idx;
  logic        started;

  // Output register.
  logic [6:0]  out_col;
  logic [7:0]  out_row;
  logic [7:0]  out_glyph;
  logic        out_on;
  logic        out_last;

  logic        mode_eff;
  logic        mode_next;
  logic [3:0]  size_next;
  logic [3:0]  hex_top;
  op_t         op;
  logic [3:0]  nibble;
  logic [3:0]  digit;
  logic [35:0] sub;
  logic [7:0]  glyph_sel;
  logic        last_sel;
  logic        emitting;
  logic [7:0]  col_inc;

  assign format_char     = s_tdata[7:0];
  assign argument_value  = s_tdata[39:8];
  assign first_of_format = s_tuser;
  assign mode_eff        = first_of_format ? 1'b0 : mode;

  assign hex_top = (size >= SIZE_RESET) ? HEX_TOP : ({size[2:0], 1'b0} - 4'd1);

  always_comb begin
    op        = OP_NONE;
    mode_next = mode_eff;
    size_next = size;
    if (!mode_eff) begin
      if (format_char == CH_PCT) begin
        mode_next = 1'b1;
        size_next = SIZE_RESET;
      end else if (format_char != CH_CR && format_char != CH_LF) begin
        op = OP_CHAR;
      end
    end else begin
      case (format_char)
        CH_PCT: begin
          op        = OP_CHAR;
          mode_next = 1'b0;
        end
        CH_H: size_next = {1'b0, size[3:1]};
        CH_L: size_next = (size >= SIZE_RESET) ? SIZE_MAX : {size[2:0], 1'b0};
        CH_X: begin
          op        = (size == 4'd0) ? OP_NONE : OP_HEX;
          mode_next = 1'b0;
        end
        CH_D: begin
          op        = OP_DEC;
          mode_next = 1'b0;
        end
        default: mode_next = mode_eff;
      endcase
    end
  end

  assign nibble = work[{idx[2:0], 2'b00} +: 4];

  // Decimal digit at the current power of ten, found by comparing against
  // every multiple of that power in parallel.
  always_comb begin
    digit = 4'd0;
    sub   = 36'd0;
    for (int d = 1; d <= 9; d++) begin
      if ({4'b0, work} >= pow10(idx) * 36'(d)) begin
        digit = 4'(d);
        sub   = pow10(idx) * 36'(d);
      end
    end
  end

  always_comb begin
    case (cmd.emit)
      EM_CHAR: begin
        glyph_sel = ch;
        last_sel  = 1'b1;
      end
      EM_MINUS: begin
        glyph_sel = CH_MINUS;
        last_sel  = 1'b0;
      end
      EM_HEX: begin
        glyph_sel = hex_glyph(nibble);
        last_sel  = (idx == 4'd0);
      end
      EM_DEC: begin
        glyph_sel = CH_ZERO + {4'b0, digit};
        last_sel  = (idx == 4'd0);
      end
      default: begin
        glyph_sel = ch;
        last_sel  = 1'b0;
      end
    endcase
  end

  assign emitting = (cmd.emit != EM_NONE);
  assign col_inc  = {1'b0, col} + 8'd1;

  always_comb begin
    status.op       = op;
    status.neg      = argument_value[31];
    status.out_free = !m_tvalid || m_tready;
    status.idx_zero = (idx == 4'd0);
    status.hex_skip = !started && (idx > 4'd1) && (nibble == 4'd0);
    status.dec_skip = !started && (idx != 4'd0) && (digit == 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      size <= SIZE_RESET;
      col  <= 7'd0;
      row  <= 8'd0;
    end else if (cmd.accept) begin
      mode <= mode_next;
      size <= size_next;
      if (!mode_eff && format_char == CH_CR) begin
        col <= 7'd0;
      end else if (!mode_eff && format_char == CH_LF) begin
        col <= 7'd0;
        if (row != ROW_LIMIT) begin
          row <= row + 8'd1;
        end
      end
    end else if (emitting) begin
      if (col_inc >= 8'(COLUMNS)) begin
        col <= 7'd0;
        if (row != ROW_LIMIT) begin
          row <= row + 8'd1;
        end
      end else begin
        col <= col_inc[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch      <= format_char;
      started <= 1'b0;
      if (format_char == CH_X) begin
        idx  <= hex_top;
        work <= argument_value;
      end else begin
        idx  <= DEC_TOP;
        work <= argument_value[31] ? (32'd0 - argument_value) : argument_value;
      end
    end else begin
      if (cmd.emit == EM_HEX || cmd.emit == EM_DEC) begin
        started <= 1'b1;
      end
      if (cmd.emit == EM_HEX || cmd.emit == EM_DEC || cmd.skip) begin
        idx <= idx - 4'd1;
      end
      if (cmd.emit == EM_DEC) begin
        work <= work - sub[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emitting) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emitting) begin
      out_col   <= col;
      out_row   <= row;
      out_glyph <= glyph_sel;
      out_on    <= ({1'b0, row} < 9'(ROWS));
      out_last  <= last_sel;
    end
  end

  assign m_tdata = {1'b0, out_glyph, out_row, out_col};
  assign m_tuser = out_on;
  assign m_tlast = out_last;

endmodule

`default_nettype wire

>>> sv/console_format_engine_core.sv
`default_nettype none

// Printf-style formatter driving a text console, one format character per
// input transaction. The slave channel carries the character and the 32-bit
// argument in s_tdata and a "first character of a format" flag in s_tuser;
// that flag drops the parser back to normal mode before the character is
// looked at. Every character that lands on the screen leaves the master
// channel as one transaction: the cell column, row and glyph in m_tdata, an
// on-screen flag in m_tuser, and m_tlast on the final cell of its input.
// The first cell of an input is written from the controller state entered
// on taking the input, once the output register is free; each leading zero
// that a conversion skips (up to six for hex, nine for decimal) holds it
// back further. An input that writes nothing (CR, LF, a size modifier, an
// ignored character) ends once taken. A plain character writes one cell,
// a hex conversion walks its nibbles from the top down, and a decimal
// conversion the powers of ten from 10^9 down after any minus sign. The
// controller's digit loop takes one digit per cycle, but a digit to be
// written waits while the output register is full. Reset puts the parser
// in normal mode with a size of four bytes, homes the cursor and empties
// the output register. When the receiver stalls, the finished cell waits
// in the output register and no further cell is written until it is taken;
// a new input is taken as soon as the previous input's last cell is there.
module console_format_engine_core
  import cfe_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // format_char[7:0], argument_value[39:8]
  input  wire logic        s_tuser,   // first_of_format[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // cell_column[6:0], cell_row[14:7], glyph[22:15]
  output logic             m_tuser,   // on_screen[0]
  output logic             m_tlast
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller walks an input through its cell writes; the datapath
  // holds the parser state, the cursor, the conversion registers and the
  // output register.
  cfe_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cfe_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // A cell that is not the last of its input means the conversion is still
  // running, so no new input may be taken.
  a_busy_mid_item: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !s_tready)
    else $error("input taken while a conversion is unfinished");

  // The cursor wraps before it ever reaches the row width.
  a_column_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, m_tdata[6:0]} < 8'(COLUMNS)))
    else $error("cell column out of range");

  // The on-screen flag follows the row of the cell.
  a_on_screen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ({1'b0, m_tdata[14:7]} < 9'(ROWS))))
    else $error("on-screen flag disagrees with cell row");

  // Controller only ever writes the output register when it is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit != EM_NONE) |-> (!m_tvalid || m_tready))
    else $error("output register overwritten before it was taken");

endmodule

`default_nettype wire

>>> test/cfe_checker.sv
`default_nettype none

// Watches both channels of the format engine, keeps its own model of the
// parser and console, and compares every screen-cell transaction with the
// oldest cell the model has produced.
module cfe_checker
  import cfe_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,
  input  wire logic        s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [23:0] m_tdata,
  input  wire logic        m_tuser,
  input  wire logic        m_tlast,
  output int               mismatches,
  output int               cells_pending,
  output int               cells_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] DEC_LEAD = 32'd1000000000;

  typedef struct packed {
    logic [6:0] column;
    logic [7:0] row;
    logic [7:0] glyph;
    logic       on_screen;
    logic       last;
  } cell_t;

  // Model state: parser mode, operand size in bytes and the console cursor.
  logic       expr_mode;
  logic [3:0] op_size;
  logic [6:0] cur_col;
  logic [7:0] cur_row;

  cell_t cell_q[$];
  cell_t step_cells[$];
  int    fail_cnt;
  int    seen_cnt;

  initial begin
    mismatches    = 0;
    cells_pending = 0;
    cells_checked = 0;
  end

  task automatic advance_row();
    cur_col = '0;
    if (cur_row != ROW_LIMIT) cur_row = cur_row + 8'd1;
  endtask

  task automatic console_put(input logic [7:0] ch);
    cell_t c;
    if (ch == CH_CR) begin
      cur_col = '0;
    end else if (ch == CH_LF) begin
      advance_row();
    end else begin
      c.column    = cur_col;
      c.row       = cur_row;
      c.glyph     = ch;
      c.on_screen = (int'(cur_row) < ROWS);
      c.last      = 1'b0;
      step_cells.push_back(c);
      cur_col = cur_col + 7'd1;
      if (int'(cur_col) >= COLUMNS) advance_row();
    end
  endtask

  // Hex starts at the top nibble of the operand size and drops leading zero
  // nibbles, but always shows the two lowest unless the size is zero.
  task automatic emit_hex(input logic [31:0] v);
    int         top;
    logic [3:0] nib;
    top = 2 * int'(op_size);
    if (top > 8) top = 8;
    top = top - 1;
    while (top > 1 && v[4*top +: 4] == 4'd0) top = top - 1;
    for (; top >= 0; top--) begin
      nib = v[4*top +: 4];
      console_put(nib < 4'd10 ? CH_ZERO + {4'b0, nib} : CH_UPPER_A + {4'b0, nib} - 8'd10);
    end
  endtask

  // Signed decimal of the full 32 bits; the negation of the most negative
  // value wraps to itself, which is the right unsigned magnitude.
  task automatic emit_dec(input logic [31:0] v);
    logic [31:0] mag;
    logic [31:0] div;
    logic [31:0] digit;
    mag = v;
    div = DEC_LEAD;
    if (v[31]) begin
      console_put(CH_MINUS);
      mag = -v;
    end
    while (div > 32'd1 && mag / div == 32'd0) div = div / 32'd10;
    while (div != 32'd0) begin
      digit = mag / div;
      console_put(CH_ZERO + digit[7:0]);
      mag = mag - digit * div;
      div = div / 32'd10;
    end
  endtask

  task automatic predict_format_char(input logic [7:0] fc, input logic [31:0] arg,
                                     input logic first);
    step_cells.delete();
    if (first) expr_mode = 1'b0;
    if (!expr_mode) begin
      if (fc == CH_PCT) begin
        expr_mode = 1'b1;
        op_size   = SIZE_RESET;
      end else begin
        console_put(fc);
      end
    end else begin
      case (fc)
        CH_PCT: begin
          console_put(fc);
          expr_mode = 1'b0;
        end
        CH_H: op_size = op_size >> 1;
        CH_L: op_size = (op_size >= SIZE_RESET) ? SIZE_MAX : op_size << 1;
        CH_X: begin
          emit_hex(arg);
          expr_mode = 1'b0;
        end
        CH_D: begin
          emit_dec(arg);
          expr_mode = 1'b0;
        end
        default: ;
      endcase
    end
    if (step_cells.size() > 0) step_cells[step_cells.size() - 1].last = 1'b1;
    foreach (step_cells[i]) cell_q.push_back(step_cells[i]);
  endtask

  always @(posedge clk) begin
    cell_t got;
    cell_t want;
    if (rst) begin
      expr_mode = 1'b0;
      op_size   = SIZE_RESET;
      cur_col   = '0;
      cur_row   = '0;
      cell_q.delete();
      fail_cnt  = 0;
      seen_cnt  = 0;
    end else begin
      // A cell leaving at this edge cannot belong to an input taken at the
      // same edge, so checking first and predicting second is safe.
      if (m_tvalid && m_tready) begin
        got = {m_tdata[6:0], m_tdata[14:7], m_tdata[22:15], m_tuser, m_tlast};
        seen_cnt++;
        if (cell_q.size() == 0) begin
          fail_cnt++;
          $display({"%0t: unexpected cell, expected none,",
                    " actual col=%0d row=%0d glyph=%h on=%b last=%b"},
                   $time, got.column, got.row, got.glyph, got.on_screen, got.last);
        end else begin
          want = cell_q.pop_front();
          if (got !== want) begin
            fail_cnt++;
            $display({"%0t: cell mismatch, expected col=%0d row=%0d glyph=%h on=%b last=%b,",
                      " actual col=%0d row=%0d glyph=%h on=%b last=%b"},
                     $time, want.column, want.row, want.glyph, want.on_screen, want.last,
                     got.column, got.row, got.glyph, got.on_screen, got.last);
          end
        end
      end
      if (s_tvalid && s_tready) predict_format_char(s_tdata[7:0], s_tdata[39:8], s_tuser);
    end
    mismatches    <= fail_cnt;
    cells_pending <= cell_q.size();
    cells_checked <= seen_cnt;
  end

endmodule

`default_nettype wire

>>> test/tb_top.sv
`default_nettype none

// Stimulus and verdict for the console format engine. Each input transaction
// carries one format character with its 32-bit argument; the checker beside
// the block predicts the screen cells and counts any disagreement.
module tb_top
  import cfe_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int RANDOM_CHARS = 200;
  localparam int LF_BURST    = 40;
  // Roughly 270 inputs, each at worst eleven cells held up by long receiver
  // stalls plus a long sender gap; this leaves a wide margin over that.
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [7:0] CH_UNKNOWN = 8'h71;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // format_char[7:0], argument_value[39:8]
  logic        s_tuser = 1'b0; // first_of_format[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // cell_column[6:0], cell_row[14:7], glyph[22:15]
  logic        m_tuser;        // on_screen[0]
  logic        m_tlast;

  int mismatches;
  int cells_pending;
  int cells_checked;
  int chars_sent = 0;
  int cycle_cnt = 0;
  int send_calm = 0;
  int ready_hold = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  console_format_engine_core #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  cfe_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .mismatches    (mismatches),
    .cells_pending (cells_pending),
    .cells_checked (cells_checked)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d cells outstanding.",
               cycle_cnt, cells_pending);
      $display("console_format_engine_core: mismatch");
      $finish;
    end
  end

  // Receiver back-pressure. Each decision holds for a while: mostly short
  // ready or stalled spells, occasionally a long stall, and now and then a
  // long stretch of steady readiness so the block also runs at full speed.
  always @(posedge clk) begin
    int r;
    if (rst) begin
      m_tready   <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        m_tready   <= 1'b1;
        ready_hold <= $urandom_range(50, 150);
      end else if (r < 60) begin
        m_tready   <= 1'b1;
        ready_hold <= $urandom_range(0, 6);
      end else if (r < 93) begin
        m_tready   <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        m_tready   <= 1'b0;
        ready_hold <= $urandom_range(10, 30);
      end
    end
  end

  // Idle cycles before the next input: mostly none or a few, sometimes a
  // long pause, with occasional runs of back-to-back transactions.
  function automatic int pick_gap();
    int r;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      send_calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Arguments lean toward the interesting shapes: extremes, small values,
  // small negatives and values with many leading zero nibbles.
  function automatic logic [31:0] pick_arg();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom;
    if (r < 60) return $urandom_range(0, 255);
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    if (r < 85) return -$urandom_range(1, 1000);
    return $urandom >> $urandom_range(0, 31);
  endfunction

  // Presents one format character and waits for its transaction. The valid
  // stays high from one character to the next unless a gap is inserted.
  task automatic send_char(input logic [7:0] fc, input logic [31:0] arg,
                           input logic first);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {arg, fc};
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  function automatic logic [7:0] pick_modifier();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return CH_H;
    if (r < 90) return CH_L;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_conversion();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return CH_X;
    if (r < 85) return CH_D;
    return CH_PCT;
  endfunction

  initial begin
    int r;
    int mods;
    int random_sent;
    bit lf_burst_done;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: printable characters including byte zero, carriage
    // return and line feed, a literal percent, hex at full size with all
    // digits, shortened hex, the size shrinking to zero and staying there,
    // long hex that drops leading zeros to two digits, the most negative
    // decimal, an ignored character inside a conversion, and a new format
    // starting in the middle of a conversion.
    send_char(CH_UPPER_A, 32'h0, 1'b1);
    send_char(8'h00, 32'hFFFF_FFFF, 1'b0);
    send_char(CH_CR, 32'h0, 1'b0);
    send_char(CH_LF, 32'h0, 1'b0);
    send_char(CH_PCT, 32'h0, 1'b0);
    send_char(CH_PCT, 32'h0, 1'b0);
    send_char(CH_PCT, 32'h0, 1'b0);
    send_char(CH_X, 32'hFFFF_FFFF, 1'b0);
    send_char(CH_PCT, 32'h0, 1'b0);
    send_char(CH_H, 32'h0, 1'b0);
    send_char(CH_X, 32'h0000_1234, 1'b0);
    send_char(CH_PCT, 32'h0, 1'b0);
    repeat (4) send_char(CH_H, 32'h0, 1'b0);
    send_char(CH_X, 32'hDEAD_BEEF, 1'b0);
    send_char(CH_PCT, 32'h0, 1'b0);
    send_char(CH_L, 32'h0, 1'b0);
    send_char(CH_X, 32'h0000_0005, 1'b0);
    send_char(CH_PCT, 32'h0, 1'b0);
    send_char(CH_D, 32'h8000_0000, 1'b0);
    send_char(CH_PCT, 32'h0, 1'b0);
    send_char(CH_UNKNOWN, 32'h0, 1'b0);
    send_char(CH_D, 32'h7FFF_FFFF, 1'b0);
    send_char(CH_PCT, 32'h0, 1'b0);
    send_char(CH_UPPER_A + 8'd1, 32'h0, 1'b1);

    // Random part, mostly well-formed conversions with random modifiers and
    // arguments, mixed with plain text, line control and broken sequences.
    random_sent   = 0;
    lf_burst_done = 1'b0;
    while (random_sent < RANDOM_CHARS) begin
      // Halfway through, a run of line feeds pushes the cursor past the
      // last visible row.
      if (!lf_burst_done && random_sent >= RANDOM_CHARS / 2) begin
        repeat (LF_BURST) send_char(CH_LF, $urandom, 1'b0);
        lf_burst_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_char(8'($urandom_range(0, 255)), pick_arg(), $urandom_range(0, 9) == 0);
        random_sent++;
      end else if (r < 45) begin
        send_char($urandom_range(0, 1) ? CH_LF : CH_CR, pick_arg(), 1'b0);
        random_sent++;
      end else if (r < 90) begin
        send_char(CH_PCT, pick_arg(), $urandom_range(0, 2) == 0);
        mods = $urandom_range(0, 3);
        repeat (mods) send_char(pick_modifier(), pick_arg(), 1'b0);
        send_char(pick_conversion(), pick_arg(), 1'b0);
        random_sent += mods + 2;
      end else begin
        // A conversion cut short by the start of a new format.
        send_char(CH_PCT, pick_arg(), 1'b0);
        send_char(8'($urandom_range(0, 255)), pick_arg(), 1'b1);
        random_sent += 2;
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (cells_pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Sent %0d format characters and checked %0d screen cells, %0d wrong.",
             chars_sent, cells_checked, mismatches);
    $display("Covered hex and decimal conversions at all sizes, wrapping and off-screen rows.");
    if (mismatches == 0 && cells_pending == 0) begin
      $display("console_format_engine_core: match");
    end else begin
      $display("console_format_engine_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> console_format_engine_core.f
sv/cfe_pkg.sv
sv/cfe_controller.sv
sv/cfe_datapath.sv
sv/console_format_engine_core.sv
test/cfe_checker.sv
test/tb_top.sv
